// File: hdl/ucep_pkg.sv
// Package: shared types, codes and descriptor ROM contents for the control endpoint engine.
package ucep_pkg;

  typedef enum logic [1:0] {
    OP_BUS_RESET = 2'd0,
    OP_SETUP     = 2'd1,
    OP_OUT_DONE  = 2'd2,
    OP_IN_DONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ARM   = 2'd1,
    ACT_STALL = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    PH_SETUP  = 2'd0,
    PH_DATA   = 2'd1,
    PH_STATUS = 2'd2
  } phase_t;

  // Back end sequencer states
  typedef enum logic [1:0] {EX_IDLE, EX_GATHER, EX_OUT} ex_state_t;

  // Classified commands handed from front to back
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_BUS_RESET,
    CMD_STALL,
    CMD_STALL_KEEP,
    CMD_ZLP,
    CMD_SET_ADDR,
    CMD_SET_CONFIG,
    CMD_SEND_SMALL,
    CMD_GET_CONFIG,
    CMD_DESC,
    CMD_SET_REPORT,
    CMD_OUT_DONE,
    CMD_IN_DONE
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] arg;        // address, config, byte count or length
    logic [7:0] base;       // descriptor ROM offset
    logic [1:0] reply_len;  // byte count of a short reply
  } cmd_item_t;

  localparam int XFER = 8;
  localparam int ROM_USED = 204;

  localparam logic [7:0] OFF_DEV  = 8'd0;
  localparam logic [7:0] OFF_CFG  = 8'd18;
  localparam logic [7:0] OFF_LANG = 8'd52;
  localparam logic [7:0] OFF_MFR  = 8'd56;
  localparam logic [7:0] OFF_PROD = 8'd102;
  localparam logic [7:0] OFF_SER  = 8'd140;
  localparam logic [7:0] OFF_RPT  = 8'd180;

  localparam logic [7:0] LEN_DEV  = 8'h12;
  localparam logic [7:0] LEN_CFG  = 8'h22;
  localparam logic [7:0] LEN_LANG = 8'd4;
  localparam logic [7:0] LEN_MFR  = 8'd46;
  localparam logic [7:0] LEN_PROD = 8'd38;
  localparam logic [7:0] LEN_SER  = 8'd40;
  localparam logic [7:0] LEN_RPT  = 8'd24;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] REQ_CLR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_SET_DESC    = 8'h07;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE   = 8'h0A;
  localparam logic [7:0] REQ_SET_IFACE   = 8'h0B;
  // Class request codes
  localparam logic [7:0] HID_GET_REPORT  = 8'h01;
  localparam logic [7:0] HID_SET_IDLE    = 8'h0A;
  localparam logic [7:0] HID_SET_REPORT  = 8'h09;
  // Descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_REPORT = 8'h22;
  // Request type groups
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;
  localparam logic [1:0] RT_RESERVED = 2'd3;

  // Descriptor ROM; addresses past the table read 0
  function automatic logic [7:0] rom_byte(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'd0: r = 8'h12; 8'd1: r = 8'h01; 8'd2: r = 8'h10; 8'd3: r = 8'h01;
      8'd4: r = 8'h00; 8'd5: r = 8'h00; 8'd6: r = 8'h00; 8'd7: r = 8'h08;
      8'd8: r = 8'h86; 8'd9: r = 8'h19; 8'd10: r = 8'h86; 8'd11: r = 8'h19;
      8'd12: r = 8'h01; 8'd13: r = 8'h00; 8'd14: r = 8'h01; 8'd15: r = 8'h02;
      8'd16: r = 8'h03; 8'd17: r = 8'h01;
      8'd18: r = 8'h09; 8'd19: r = 8'h02; 8'd20: r = 8'h22; 8'd21: r = 8'h00;
      8'd22: r = 8'h01; 8'd23: r = 8'h01; 8'd24: r = 8'h00; 8'd25: r = 8'hC0;
      8'd26: r = 8'h32;
      8'd27: r = 8'h09; 8'd28: r = 8'h04; 8'd29: r = 8'h00; 8'd30: r = 8'h00;
      8'd31: r = 8'h01; 8'd32: r = 8'h03; 8'd33: r = 8'h00; 8'd34: r = 8'h00;
      8'd35: r = 8'h00;
      8'd36: r = 8'h09; 8'd37: r = 8'h21; 8'd38: r = 8'h11; 8'd39: r = 8'h01;
      8'd40: r = 8'h00; 8'd41: r = 8'h01; 8'd42: r = 8'h22; 8'd43: r = 8'h18;
      8'd44: r = 8'h00;
      8'd45: r = 8'h07; 8'd46: r = 8'h05; 8'd47: r = 8'h81; 8'd48: r = 8'h03;
      8'd49: r = 8'h08; 8'd50: r = 8'h00; 8'd51: r = 8'h05;
      8'd52: r = 8'h04; 8'd53: r = 8'h03; 8'd54: r = 8'h09; 8'd55: r = 8'h04;
      8'd56: r = 8'h2E; 8'd57: r = 8'h03; 8'd58: r = 8'h48; 8'd60: r = 8'h75;
      8'd62: r = 8'h6E; 8'd64: r = 8'h67; 8'd66: r = 8'h20; 8'd68: r = 8'h43;
      8'd70: r = 8'h75; 8'd72: r = 8'h6F; 8'd74: r = 8'h6E; 8'd76: r = 8'h67;
      8'd78: r = 8'h20; 8'd80: r = 8'h45; 8'd82: r = 8'h6C; 8'd84: r = 8'h65;
      8'd86: r = 8'h63; 8'd88: r = 8'h74; 8'd90: r = 8'h72; 8'd92: r = 8'h6F;
      8'd94: r = 8'h6E; 8'd96: r = 8'h69; 8'd98: r = 8'h63; 8'd100: r = 8'h73;
      8'd102: r = 8'h26; 8'd103: r = 8'h03; 8'd104: r = 8'h55; 8'd106: r = 8'h53;
      8'd108: r = 8'h42; 8'd110: r = 8'h20; 8'd112: r = 8'h48; 8'd114: r = 8'h49;
      8'd116: r = 8'h44; 8'd118: r = 8'h20; 8'd120: r = 8'h42; 8'd122: r = 8'h4F;
      8'd124: r = 8'h4F; 8'd126: r = 8'h54; 8'd128: r = 8'h4C; 8'd130: r = 8'h4F;
      8'd132: r = 8'h41; 8'd134: r = 8'h44; 8'd136: r = 8'h45; 8'd138: r = 8'h52;
      8'd140: r = 8'h28; 8'd141: r = 8'h03; 8'd142: r = 8'h77; 8'd144: r = 8'h77;
      8'd146: r = 8'h77; 8'd148: r = 8'h2E; 8'd150: r = 8'h76; 8'd152: r = 8'h69;
      8'd154: r = 8'h64; 8'd156: r = 8'h69; 8'd158: r = 8'h65; 8'd160: r = 8'h75;
      8'd162: r = 8'h6B; 8'd164: r = 8'h68; 8'd166: r = 8'h69; 8'd168: r = 8'h65;
      8'd170: r = 8'h6E; 8'd172: r = 8'h2E; 8'd174: r = 8'h6F; 8'd176: r = 8'h72;
      8'd178: r = 8'h67;
      8'd180: r = 8'h06; 8'd181: r = 8'h00; 8'd182: r = 8'hFF; 8'd183: r = 8'h09;
      8'd184: r = 8'h01; 8'd185: r = 8'hA1; 8'd186: r = 8'h01; 8'd187: r = 8'h15;
      8'd188: r = 8'h00; 8'd189: r = 8'h26; 8'd190: r = 8'hFF; 8'd191: r = 8'h00;
      8'd192: r = 8'h75; 8'd193: r = 8'h08; 8'd194: r = 8'h85; 8'd195: r = 8'h01;
      8'd196: r = 8'h95; 8'd197: r = 8'h47; 8'd198: r = 8'h09; 8'd199: r = 8'h00;
      8'd200: r = 8'hB2; 8'd201: r = 8'h02; 8'd202: r = 8'h01; 8'd203: r = 8'hC0;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ucep_if.sv
// Interfaces: valid/ready event and result channels.
interface ucep_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_length;
  modport source (output valid, operation, request_type, request_code, request_value,
                  request_length, input ready);
  modport sink (input valid, operation, request_type, request_code, request_value,
                request_length, output ready);
endinterface

interface ucep_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tx_action;
  logic [3:0]  tx_count;
  logic [63:0] tx_data;
  logic        rx_armed;
  logic [6:0]  device_address;
  logic        address_enable;
  logic [7:0]  configuration;
  logic [1:0]  control_phase;
  logic        interrupt_endpoint_on;
  modport source (output valid, tx_action, tx_count, tx_data, rx_armed, device_address,
                  address_enable, configuration, control_phase, interrupt_endpoint_on,
                  input ready);
  modport sink (input valid, tx_action, tx_count, tx_data, rx_armed, device_address,
                address_enable, configuration, control_phase, interrupt_endpoint_on,
                output ready);
endinterface

// File: hdl/usb_control_endpoint_engine.sv
// Top level: USB endpoint 0 control-transfer engine.
// Usage:
//   ev  : sink channel of bus events (bus reset, setup, OUT done, IN done)
//         with the setup packet fields.
//   res : source channel, one result per event: IN action, byte count,
//         packet bytes, OUT re-arm flag and the endpoint state after it.
// A front decoder classifies each event in the cycle it is taken and
// pushes a command into a two-entry queue; ev.ready is low only when the
// queue is full. The back end pops one command, updates the state, then
// fetches descriptor bytes from the ROM one byte per cycle.
// The result is registered: a taken event is stored in the queue, then
// the back end pops it and registers the new state and result; for an IN
// packet of n descriptor bytes (n up to 8) it first fetches them from the
// ROM. The back end takes no new command until its result has been taken.
// Reset (rst, synchronous) empties the queue and returns the state to
// setup phase, address 0 enabled, configuration 0.
// When the receiver stalls, the result holds and the queue fills, then
// ev.ready drops; no transfer is lost.
module usb_control_endpoint_engine #(
  parameter int MAX_PACKET = 8,
  parameter int ROM_BYTES  = 256
) (
  input logic           clk,
  input logic           rst,
  ucep_event_if.sink    ev,
  ucep_result_if.source res
);
  import ucep_pkg::*;

  cmd_item_t dec_item;
  cmd_item_t head;
  logic      q_full, q_empty, q_pop;

  ucep_decode u_decode (
    .operation      (ev.operation),
    .request_type   (ev.request_type),
    .request_code   (ev.request_code),
    .request_value  (ev.request_value),
    .request_length (ev.request_length),
    .item           (dec_item)
  );

  assign ev.ready = ~q_full;

  ucep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev.valid & ~q_full),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  ucep_exec #(.ROM_BYTES(ROM_BYTES)) u_exec (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (~q_empty),
    .cmd       (head),
    .cmd_pop   (q_pop),
    .res       (res)
  );

`ifndef SYNTH
  // Packet size must be at least the transfer chunk width
  a_max_packet: assert property (@(posedge clk) MAX_PACKET >= XFER)
    else $error("packet size below chunk size");
  // No IN count above the chunk size
  a_count: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.tx_count <= 4'(XFER))
    else $error("tx_count too large");
  // Non-arm results carry no bytes
  a_count_arm: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.tx_action != ACT_ARM |-> res.tx_count == 4'd0)
    else $error("count without arm");
  // A stall result that shows the reset state has the OUT re-armed
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.tx_action == ACT_STALL && res.device_address == 7'd0
    && res.configuration == 8'd0 && !res.interrupt_endpoint_on |-> res.rx_armed)
    else $error("stall without rx re-arm");
`endif

endmodule

// File: hdl/ucep_decode.sv
// Front end: classifies each event into a command for the back end.
module ucep_decode (
  input  logic [1:0]          operation,
  input  logic [7:0]          request_type,
  input  logic [7:0]          request_code,
  input  logic [15:0]         request_value,
  input  logic [15:0]         request_length,
  output ucep_pkg::cmd_item_t item
);
  import ucep_pkg::*;

  logic [4:0] rcpt;
  logic [7:0] idx;
  logic [7:0] dtype;
  logic [7:0] full;
  logic [7:0] cap;
  logic [7:0] dbase;
  logic       known;

  assign rcpt  = request_type[4:0];
  assign idx   = request_value[7:0];
  assign dtype = request_value[15:8];

  // Descriptor table lookup
  always_comb begin
    known = 1'b1;
    full  = LEN_DEV;
    dbase = OFF_DEV;
    priority if (dtype == DT_DEVICE) begin
      full = LEN_DEV;  dbase = OFF_DEV;
    end else if (dtype == DT_CONFIG) begin
      full = LEN_CFG;  dbase = OFF_CFG;
    end else if (dtype == DT_STRING && idx == 8'd0) begin
      full = LEN_LANG; dbase = OFF_LANG;
    end else if (dtype == DT_STRING && idx == 8'd1) begin
      full = LEN_MFR;  dbase = OFF_MFR;
    end else if (dtype == DT_STRING && idx == 8'd2) begin
      full = LEN_PROD; dbase = OFF_PROD;
    end else if (dtype == DT_STRING && idx == 8'd3) begin
      full = LEN_SER;  dbase = OFF_SER;
    end else if (dtype == DT_REPORT && idx == 8'd0) begin
      full = LEN_RPT;  dbase = OFF_RPT;
    end else begin
      known = 1'b0;
    end
  end

  assign cap = (request_length > {8'd0, full}) ? full : request_length[7:0];

  // Command classification
  always_comb begin
    item.cmd       = CMD_NOP;
    item.arg       = 8'd0;
    item.base      = dbase;
    item.reply_len = 2'd0;
    unique case (op_t'(operation))
      OP_BUS_RESET: item.cmd = CMD_BUS_RESET;
      OP_OUT_DONE:  item.cmd = CMD_OUT_DONE;
      OP_IN_DONE:   item.cmd = CMD_IN_DONE;
      OP_SETUP: begin
        unique case (request_type[6:5])
          RT_STANDARD: begin
            unique case (request_code)
              REQ_GET_STATUS: begin
                if (rcpt <= 5'd2) begin
                  item.cmd = CMD_SEND_SMALL; item.reply_len = 2'd2;
                end else item.cmd = CMD_STALL;
              end
              REQ_CLR_FEATURE, REQ_SET_FEATURE:
                item.cmd = (rcpt == 5'd0 || rcpt == 5'd2) ? CMD_ZLP : CMD_STALL;
              REQ_SET_ADDRESS: begin
                item.cmd = CMD_SET_ADDR; item.arg = idx;
              end
              REQ_GET_DESC: begin
                if (known) begin
                  item.cmd = CMD_DESC; item.arg = cap;
                end else if (dtype == DT_REPORT) item.cmd = CMD_NOP;
                else item.cmd = CMD_STALL;
              end
              REQ_SET_DESC:   item.cmd = CMD_STALL;
              REQ_GET_CONFIG: item.cmd = CMD_GET_CONFIG;
              REQ_SET_CONFIG: begin
                item.cmd = CMD_SET_CONFIG; item.arg = idx;
              end
              REQ_GET_IFACE: begin
                item.cmd = CMD_SEND_SMALL; item.reply_len = 2'd1;
              end
              REQ_SET_IFACE: item.cmd = CMD_ZLP;
              default: item.cmd = CMD_NOP;
            endcase
          end
          RT_CLASS: begin
            unique case (request_code)
              HID_SET_IDLE, HID_GET_REPORT: item.cmd = CMD_STALL;
              HID_SET_REPORT: begin
                item.cmd = CMD_SET_REPORT; item.arg = request_length[7:0];
              end
              default: item.cmd = CMD_NOP;
            endcase
          end
          RT_RESERVED: item.cmd = CMD_STALL_KEEP;
          default: item.cmd = CMD_NOP;
        endcase
      end
      default: item.cmd = CMD_NOP;
    endcase
  end

endmodule

// File: hdl/ucep_queue.sv
// Two-entry command queue between front and back end.
module ucep_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ucep_pkg::cmd_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output ucep_pkg::cmd_item_t head
);
  import ucep_pkg::*;

  cmd_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/ucep_exec.sv
// Back end: holds endpoint state, executes commands and gathers ROM bytes one per cycle.
module ucep_exec #(
  parameter int ROM_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  ucep_pkg::cmd_item_t cmd,
  output logic                cmd_pop,
  ucep_result_if.source       res
);
  import ucep_pkg::*;

  ex_state_t   state, state_next;
  phase_t      phase_reg;
  logic [7:0]  remaining_bytes, rom_offset, pending_address, current_config;
  logic [6:0]  current_address;
  logic        address_enabled_flag, interrupt_ep_enabled;
  logic [3:0]  gather_n;    // bytes to fetch
  logic [3:0]  gather_i;    // byte being fetched
  logic [63:0] data_acc;
  logic [1:0]  act_reg;
  logic [3:0]  cnt_reg;
  logic        rxa_reg;
  logic        send_rom;
  logic [7:0]  gbyte;
  logic [7:0]  gaddr;
  logic        out_take;

  // State after executing the head command
  phase_t     ph_n;
  logic [7:0] rem_n, off_n, pend_n, cfg_n;
  logic [6:0] addr_n;
  logic       aen_n, iep_n;
  logic [1:0] act_n;
  logic [3:0] cnt_n;
  logic       rxa_n;
  logic [63:0] dat_n;

  assign out_take = res.valid & res.ready;
  assign cmd_pop  = (state == EX_IDLE) & cmd_valid;

  // Command execution
  always_comb begin
    ph_n = phase_reg; rem_n = remaining_bytes; off_n = rom_offset;
    pend_n = pending_address; cfg_n = current_config; addr_n = current_address;
    aen_n = address_enabled_flag; iep_n = interrupt_ep_enabled;
    act_n = ACT_NONE; cnt_n = 4'd0; rxa_n = 1'b0; dat_n = 64'd0; send_rom = 1'b0;
    unique case (cmd.cmd)
      CMD_BUS_RESET: begin
        ph_n = PH_SETUP; rem_n = 8'd0; off_n = 8'd0; pend_n = 8'd0; addr_n = 7'd0;
        aen_n = 1'b1; cfg_n = 8'd0; iep_n = 1'b0; act_n = ACT_STALL; rxa_n = 1'b1;
      end
      CMD_STALL: begin
        act_n = ACT_STALL; rxa_n = 1'b1; ph_n = PH_SETUP;
      end
      CMD_STALL_KEEP: begin
        act_n = ACT_STALL; rxa_n = 1'b1;
      end
      CMD_ZLP: begin
        act_n = ACT_ARM; ph_n = PH_STATUS;
      end
      CMD_SET_ADDR: begin
        pend_n = cmd.arg; act_n = ACT_ARM; ph_n = PH_STATUS;
      end
      CMD_SET_CONFIG: begin
        cfg_n = cmd.arg; iep_n = 1'b1; act_n = ACT_ARM; ph_n = PH_STATUS;
      end
      CMD_SEND_SMALL: begin
        act_n = ACT_ARM; cnt_n = {2'd0, cmd.reply_len}; rem_n = {6'd0, cmd.reply_len};
        ph_n = PH_DATA;
      end
      CMD_GET_CONFIG: begin
        act_n = ACT_ARM; cnt_n = 4'd1; dat_n = {56'd0, current_config}; rem_n = 8'd1;
        ph_n = PH_DATA;
      end
      CMD_DESC: begin
        off_n = cmd.base; rem_n = cmd.arg; ph_n = PH_DATA; rxa_n = 1'b1; send_rom = 1'b1;
      end
      CMD_SET_REPORT: begin
        rem_n = cmd.arg; off_n = 8'd0; ph_n = PH_DATA; rxa_n = 1'b1;
      end
      CMD_OUT_DONE: begin
        if (phase_reg == PH_DATA) begin
          if (remaining_bytes <= 8'(XFER)) begin
            act_n = ACT_ARM; ph_n = PH_STATUS;
          end else begin
            off_n = rom_offset + 8'(XFER);
            rem_n = remaining_bytes - 8'(XFER);
            rxa_n = (rem_n >= 8'(XFER));
          end
        end else if (phase_reg == PH_STATUS) ph_n = PH_SETUP;
      end
      CMD_IN_DONE: begin
        if (phase_reg == PH_DATA) begin
          if (remaining_bytes <= 8'(XFER)) begin
            rem_n = 8'd0; rxa_n = 1'b1; act_n = ACT_ARM; ph_n = PH_STATUS;
          end else begin
            off_n = rom_offset + 8'(XFER);
            rem_n = remaining_bytes - 8'(XFER);
            send_rom = 1'b1;
          end
        end else if (phase_reg == PH_STATUS) begin
          if (pending_address != 8'd0) begin
            addr_n = pending_address[6:0]; aen_n = 1'b1; pend_n = 8'd0;
          end
          ph_n = PH_SETUP; rxa_n = 1'b1;
        end
      end
      default: ;
    endcase
    if (send_rom) begin
      act_n = ACT_ARM;
      cnt_n = (rem_n < 8'(XFER)) ? rem_n[3:0] : 4'(XFER);
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      EX_IDLE:   if (cmd_valid) state_next = (send_rom && cnt_n != 4'd0) ? EX_GATHER : EX_OUT;
      EX_GATHER: if (gather_i + 4'd1 == gather_n) state_next = EX_OUT;
      EX_OUT:    if (out_take) state_next = EX_IDLE;
      default:   state_next = EX_IDLE;
    endcase
  end

  // ROM fetch, one byte per cycle
  assign gaddr = rom_offset + {4'd0, gather_i};
  assign gbyte = ({3'd0, gaddr} < 11'(ROM_BYTES)) ? rom_byte(gaddr) : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EX_IDLE;
      phase_reg <= PH_SETUP; remaining_bytes <= 8'd0; rom_offset <= 8'd0;
      pending_address <= 8'd0; current_address <= 7'd0; address_enabled_flag <= 1'b1;
      current_config <= 8'd0; interrupt_ep_enabled <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        phase_reg <= ph_n; remaining_bytes <= rem_n; rom_offset <= off_n;
        pending_address <= pend_n; current_address <= addr_n;
        address_enabled_flag <= aen_n; current_config <= cfg_n;
        interrupt_ep_enabled <= iep_n;
      end
    end
  end

  // Result payload and gather datapath
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      act_reg <= act_n; cnt_reg <= cnt_n; rxa_reg <= rxa_n; data_acc <= dat_n;
      gather_n <= cnt_n; gather_i <= 4'd0;
    end else if (state == EX_GATHER) begin
      data_acc[gather_i[2:0]*8 +: 8] <= gbyte;
      gather_i <= gather_i + 4'd1;
    end
  end

  // Result outputs
  always_comb begin
    res.valid                 = (state == EX_OUT);
    res.tx_action             = act_reg;
    res.tx_count              = cnt_reg;
    res.tx_data               = data_acc;
    res.rx_armed              = rxa_reg;
    res.device_address        = current_address;
    res.address_enable        = address_enabled_flag;
    res.configuration         = current_config;
    res.control_phase         = phase_reg;
    res.interrupt_endpoint_on = interrupt_ep_enabled;
  end

endmodule

// File: sim/ucep_checker.sv
// Checker: watches the event and result channels, predicts each result and compares it.
`timescale 1ns / 100ps
module ucep_checker (
  input  logic      clk,
  input  logic      rst,
  ucep_event_if     ev,
  ucep_result_if    res,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);
  import ucep_pkg::*;

  typedef struct packed {
    act_t        action;
    logic [3:0]  count;
    logic [63:0] data;
    logic        rearm;
    logic [6:0]  addr;
    logic        addr_en;
    logic [7:0]  cfg;
    phase_t      phase;
    logic        intr_on;
  } ep_result_t;

  ep_result_t expected_q[$];

  // predictor's copy of the endpoint state
  phase_t     m_phase;
  logic [7:0] m_remain;
  logic [7:0] m_offset;
  logic [7:0] m_pend_addr;
  logic [6:0] m_addr;
  logic       m_addr_en;
  logic [7:0] m_cfg;
  logic       m_intr;

  // descriptor bytes as the device would see them
  function automatic logic [7:0] desc_at(input int a);
    logic [7:0] tbl[204] = '{
      8'h12,8'h01,8'h10,8'h01,8'h00,8'h00,8'h00,8'h08,8'h86,8'h19,8'h86,8'h19,8'h01,8'h00,
      8'h01,8'h02,8'h03,8'h01,
      8'h09,8'h02,8'h22,8'h00,8'h01,8'h01,8'h00,8'hC0,8'h32,
      8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h00,8'h00,8'h00,
      8'h09,8'h21,8'h11,8'h01,8'h00,8'h01,8'h22,8'h18,8'h00,
      8'h07,8'h05,8'h81,8'h03,8'h08,8'h00,8'h05,
      8'h04,8'h03,8'h09,8'h04,
      8'h2E,8'h03,8'h48,0,8'h75,0,8'h6E,0,8'h67,0,8'h20,0,8'h43,0,8'h75,0,8'h6F,0,8'h6E,0,
      8'h67,0,8'h20,0,8'h45,0,8'h6C,0,8'h65,0,8'h63,0,8'h74,0,8'h72,0,8'h6F,0,8'h6E,0,
      8'h69,0,8'h63,0,8'h73,0,
      8'h26,8'h03,8'h55,0,8'h53,0,8'h42,0,8'h20,0,8'h48,0,8'h49,0,8'h44,0,8'h20,0,8'h42,0,
      8'h4F,0,8'h4F,0,8'h54,0,8'h4C,0,8'h4F,0,8'h41,0,8'h44,0,8'h45,0,8'h52,0,
      8'h28,8'h03,8'h77,0,8'h77,0,8'h77,0,8'h2E,0,8'h76,0,8'h69,0,8'h64,0,8'h69,0,8'h65,0,
      8'h75,0,8'h6B,0,8'h68,0,8'h69,0,8'h65,0,8'h6E,0,8'h2E,0,8'h6F,0,8'h72,0,8'h67,0,
      8'h06,8'h00,8'hFF,8'h09,8'h01,8'hA1,8'h01,8'h15,8'h00,8'h26,8'hFF,8'h00,
      8'h75,8'h08,8'h85,8'h01,8'h95,8'h47,8'h09,8'h00,8'hB2,8'h02,8'h01,8'hC0};
    if (a >= ROM_USED) return 8'h00;
    return tbl[a];
  endfunction

  task automatic clear_state();
    m_phase = PH_SETUP; m_remain = '0; m_offset = '0; m_pend_addr = '0;
    m_addr = '0; m_addr_en = 1'b1; m_cfg = '0; m_intr = 1'b0;
  endtask

  task automatic load_packet(inout ep_result_t r);
    int n;
    n = (m_remain < XFER) ? int'(m_remain) : XFER;
    r.action = ACT_ARM; r.count = n[3:0]; r.data = '0;
    for (int i = 0; i < n; i++) r.data[8*i +: 8] = desc_at(int'(m_offset) + i);
  endtask

  task automatic stall_to_setup(inout ep_result_t r);
    r.action = ACT_STALL; r.rearm = 1'b1; m_phase = PH_SETUP;
  endtask

  task automatic status_zlp(inout ep_result_t r);
    r.action = ACT_ARM; r.count = '0; m_phase = PH_STATUS;
  endtask

  task automatic short_reply(inout ep_result_t r, input logic [3:0] n, input logic [63:0] b);
    r.action = ACT_ARM; r.count = n; r.data = b; m_remain = {4'd0, n}; m_phase = PH_DATA;
  endtask

  task automatic open_desc(inout ep_result_t r, input logic [7:0] base, input logic [7:0] full,
                           input logic [15:0] len);
    m_offset = base;
    m_remain = (len > {8'd0, full}) ? full : len[7:0];
    m_phase = PH_DATA; r.rearm = 1'b1;
    load_packet(r);
  endtask

  task automatic predict_event(input logic [1:0] op, input logic [7:0] rtype,
                               input logic [7:0] code, input logic [15:0] value,
                               input logic [15:0] len);
    ep_result_t r;
    logic [4:0] rcpt;
    logic [7:0] idx;
    r = '0;
    rcpt = rtype[4:0];
    idx = value[7:0];
    case (op_t'(op))
      OP_BUS_RESET: begin
        clear_state(); r.action = ACT_STALL; r.rearm = 1'b1;
      end
      OP_SETUP: begin
        if (rtype[6:5] == RT_STANDARD) begin
          case (code)
            REQ_GET_STATUS: if (rcpt <= 5'd2) short_reply(r, 4'd2, '0); else stall_to_setup(r);
            REQ_CLR_FEATURE, REQ_SET_FEATURE:
              if (rcpt == 5'd0 || rcpt == 5'd2) status_zlp(r); else stall_to_setup(r);
            REQ_SET_ADDRESS: begin m_pend_addr = idx; status_zlp(r); end
            REQ_GET_DESC: begin
              case (value[15:8])
                DT_DEVICE: open_desc(r, OFF_DEV, LEN_DEV, len);
                DT_CONFIG: open_desc(r, OFF_CFG, LEN_CFG, len);
                DT_STRING: begin
                  if (idx == 8'd0) open_desc(r, OFF_LANG, LEN_LANG, len);
                  else if (idx == 8'd1) open_desc(r, OFF_MFR, LEN_MFR, len);
                  else if (idx == 8'd2) open_desc(r, OFF_PROD, LEN_PROD, len);
                  else if (idx == 8'd3) open_desc(r, OFF_SER, LEN_SER, len);
                  else stall_to_setup(r);
                end
                DT_REPORT: if (idx == 8'd0) open_desc(r, OFF_RPT, LEN_RPT, len);
                default: stall_to_setup(r);
              endcase
            end
            REQ_SET_DESC: stall_to_setup(r);
            REQ_GET_CONFIG: short_reply(r, 4'd1, {56'd0, m_cfg});
            REQ_SET_CONFIG: begin m_cfg = idx; m_intr = 1'b1; status_zlp(r); end
            REQ_GET_IFACE: short_reply(r, 4'd1, '0);
            REQ_SET_IFACE: status_zlp(r);
            default: ;
          endcase
        end else if (rtype[6:5] == RT_CLASS) begin
          case (code)
            HID_SET_IDLE, HID_GET_REPORT: stall_to_setup(r);
            HID_SET_REPORT: begin
              m_remain = len[7:0]; m_offset = '0; m_phase = PH_DATA; r.rearm = 1'b1;
            end
            default: ;
          endcase
        end else if (rtype[6:5] == RT_RESERVED) begin
          r.action = ACT_STALL; r.rearm = 1'b1;
        end
      end
      OP_OUT_DONE: begin
        if (m_phase == PH_DATA) begin
          if (m_remain <= 8'(XFER)) status_zlp(r);
          else begin
            m_offset += 8'(XFER); m_remain -= 8'(XFER);
            r.rearm = (m_remain >= 8'(XFER));
          end
        end else if (m_phase == PH_STATUS) m_phase = PH_SETUP;
      end
      default: begin
        if (m_phase == PH_DATA) begin
          if (m_remain <= 8'(XFER)) begin
            m_remain = '0; r.rearm = 1'b1; status_zlp(r);
          end else begin
            m_offset += 8'(XFER); m_remain -= 8'(XFER); load_packet(r);
          end
        end else if (m_phase == PH_STATUS) begin
          // the new address takes effect once status completes
          if (m_pend_addr != 8'd0) begin
            m_addr = m_pend_addr[6:0]; m_addr_en = 1'b1; m_pend_addr = '0;
          end
          m_phase = PH_SETUP; r.rearm = 1'b1;
        end
      end
    endcase
    r.addr = m_addr; r.addr_en = m_addr_en; r.cfg = m_cfg; r.phase = m_phase;
    r.intr_on = m_intr;
    expected_q.push_back(r);
  endtask

  task automatic report_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: mismatch %s expected %h actual %h", $time, name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ep_result_t e;
    if (rst) begin
      clear_state();
      expected_q.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      // compare first so a same-edge event does not overtake
      if (res.valid && res.ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual action %0d", $time, res.tx_action);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          report_field("tx_action", 64'(e.action), 64'(res.tx_action));
          report_field("tx_count", 64'(e.count), 64'(res.tx_count));
          report_field("tx_data", e.data, res.tx_data);
          report_field("rx_armed", 64'(e.rearm), 64'(res.rx_armed));
          report_field("device_address", 64'(e.addr), 64'(res.device_address));
          report_field("address_enable", 64'(e.addr_en), 64'(res.address_enable));
          report_field("configuration", 64'(e.cfg), 64'(res.configuration));
          report_field("control_phase", 64'(e.phase), 64'(res.control_phase));
          report_field("interrupt_endpoint_on", 64'(e.intr_on),
                       64'(res.interrupt_endpoint_on));
        end
      end
      if (ev.valid && ev.ready)
        predict_event(ev.operation, ev.request_type, ev.request_code, ev.request_value,
                      ev.request_length);
    end
    pending_count = expected_q.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: drives control events into the endpoint engine and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
  import ucep_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_count, result_count;
  int   cycle_count = 0;
  int   hold_cycles = 0;
  int   events_sent = 0;
  bit   stimulus_done = 0;

  ucep_event_if  ev();
  ucep_result_if res();

  usb_control_endpoint_engine uut (.clk(clk), .rst(rst), .ev(ev.sink), .res(res.source));
  ucep_checker chk (.clk(clk), .rst(rst), .ev(ev), .res(res), .fail_count(fail_count),
                    .pending_count(pending_count), .result_count(result_count));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the event queue backs up
  initial begin
    int gap;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        res.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = (events_sent % 400 < 100) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // valid stays high into the next event when no gap is drawn
  task automatic send_event(input op_t op, input logic [7:0] rtype, input logic [7:0] code,
                            input logic [15:0] value, input logic [15:0] len);
    int gap;
    gap = (events_sent % 400 < 100) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      ev.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ev.valid <= 1'b1;
    ev.operation <= op;
    ev.request_type <= rtype;
    ev.request_code <= code;
    ev.request_value <= value;
    ev.request_length <= len;
    @(posedge clk);
    while (!ev.ready) @(posedge clk);
    @(negedge clk);
    events_sent++;
  endtask

  task automatic std_setup(input logic [7:0] code, input logic [15:0] value,
                           input logic [15:0] len);
    send_event(OP_SETUP, 8'h80, code, value, len);
  endtask

  // send n IN done or OUT done events to move through the data and status stages
  task automatic run_stages(input bit out_dir, input int n);
    for (int i = 0; i < n; i++)
      send_event(out_dir ? OP_OUT_DONE : OP_IN_DONE, 8'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom));
  endtask

  task automatic random_transfer();
    int kind;
    logic [15:0] val;
    logic [15:0] len;
    logic [7:0] dtype;
    kind = $urandom_range(0, 15);
    len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
    case (kind)
      0, 1, 2, 3: begin
        case ($urandom_range(0, 5))
          0: dtype = DT_DEVICE;
          1: dtype = DT_CONFIG;
          2, 3: dtype = DT_STRING;
          4: dtype = DT_REPORT;
          default: dtype = 8'($urandom);
        endcase
        val = {dtype, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4))};
        send_event(OP_SETUP, {1'b1, 2'b00, 5'($urandom)}, REQ_GET_DESC, val, len);
        run_stages(1'b0, $urandom_range(1, 8));
        run_stages(1'b1, 1);
      end
      4: begin
        std_setup(REQ_SET_ADDRESS, 16'($urandom), 16'd0);
        run_stages(1'b0, 1);
      end
      5: begin
        send_event(OP_SETUP, 8'h00, REQ_SET_CONFIG, 16'($urandom), 16'd0);
        run_stages(1'b0, 1);
      end
      6: begin
        send_event(OP_SETUP, {3'b100, 5'($urandom_range(0, 4))}, REQ_GET_STATUS, 16'd0,
                   16'd2);
        run_stages(1'b0, 2); run_stages(1'b1, 1);
      end
      7: begin
        send_event(OP_SETUP, {3'b000, 5'($urandom)},
                   $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLR_FEATURE,
                   16'($urandom), 16'd0);
        run_stages(1'b0, 1);
      end
      8: begin
        std_setup($urandom_range(0, 1) ? REQ_GET_CONFIG : REQ_GET_IFACE, 16'd0, 16'd1);
        run_stages(1'b0, 2); run_stages(1'b1, 1);
      end
      9: begin
        send_event(OP_SETUP, 8'h21, HID_SET_REPORT, 16'($urandom), len);
        run_stages(1'b1, $urandom_range(1, 10));
        run_stages(1'b0, 1);
      end
      10: begin
        send_event(OP_SETUP, {1'($urandom), 2'b01, 5'($urandom)},
                   $urandom_range(0, 1) ? HID_SET_IDLE : HID_GET_REPORT, 16'($urandom), len);
      end
      11: begin
        std_setup($urandom_range(0, 1) ? REQ_SET_IFACE : REQ_SET_DESC, 16'($urandom), 16'd0);
        run_stages(1'b0, 1);
      end
      12: send_event(OP_BUS_RESET, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      default: begin
        // noise: random setup, OUT done or IN done events with random fields
        send_event(op_t'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), 16'($urandom),
                   16'($urandom));
      end
    endcase
  endtask

  initial begin
    ev.valid = 1'b0;
    ev.operation = OP_BUS_RESET;
    ev.request_type = '0;
    ev.request_code = '0;
    ev.request_value = '0;
    ev.request_length = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: enumeration flow and the odd cases
    send_event(OP_OUT_DONE, 8'd0, 8'd0, 16'd0, 16'd0);
    send_event(OP_IN_DONE, 8'd0, 8'd0, 16'd0, 16'd0);
    std_setup(REQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'hFFFF);
    run_stages(1'b0, 4); run_stages(1'b1, 1);
    std_setup(REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF);
    run_stages(1'b0, 1);
    std_setup(REQ_GET_DESC, {DT_CONFIG, 8'd0}, 16'd9);
    send_event(OP_OUT_DONE, 8'd0, 8'd0, 16'd0, 16'd0);
    send_event(OP_SETUP, 8'h81, REQ_GET_DESC, {DT_REPORT, 8'd1}, 16'd24);
    send_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, 8'd9}, 16'd24);
    send_event(OP_SETUP, 8'h00, REQ_SET_CONFIG, 16'h00FF, 16'd0);
    run_stages(1'b0, 1);
    send_event(OP_SETUP, 8'h05, REQ_SET_FEATURE, 16'd0, 16'd0);
    send_event(OP_SETUP, 8'h60, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_event(OP_SETUP, 8'h40, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_event(OP_SETUP, 8'h00, 8'hFF, 16'd0, 16'd0);
    send_event(OP_SETUP, 8'h21, HID_SET_REPORT, 16'd0, 16'h00FF);
    send_event(OP_IN_DONE, 8'd0, 8'd0, 16'd0, 16'd0);
    send_event(OP_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);

    // long receiver hold-off while events keep coming
    hold_cycles = 300;
    while (events_sent < 1650) random_transfer();
    ev.valid <= 1'b0;
    stimulus_done = 1;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d events and %0d results covering descriptors, addressing, config,",
             events_sent, result_count);
    $display("features, HID class requests, stalls, bus resets and out-of-phase events.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
